/* rtl/cmta_pkg.sv */
package cmta_pkg;

  localparam int FRAMES_PER_MESSAGE = 5;
  localparam int SUM_BYTES          = 39;
  localparam int NUM_SENSORS        = 9;
  localparam int QUEUE_DEPTH        = 2;

  localparam int CNT_W   = $clog2(FRAMES_PER_MESSAGE + 1);
  localparam int RAW_W   = 64 * FRAMES_PER_MESSAGE;
  localparam int CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_EXT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd3;

  localparam logic [28:0] RESET_ID      = 29'h7FB;
  localparam logic [3:0]  RESET_LEN     = 4'd8;
  localparam logic [15:0] RESET_TIMEOUT = 16'd1000;

  localparam logic [7:0] MARKER_B0 = 8'hFB;
  localparam logic [7:0] MARKER_B1 = 8'hFA;
  localparam logic [7:0] SYNC_B0   = 8'h1E;
  localparam logic [7:0] SYNC_B1   = 8'hFC;
  localparam int         SYNC_POS  = 30;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ITEM_TICK,
    ITEM_FRAME,
    ITEM_SKIP
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [63:0] data;
    logic [7:0]  mask;
    logic        marker;
  } cmta_item_t;

  typedef struct packed {
    logic                          complete;
    logic                          connected;
    logic [NUM_SENSORS-1:0][15:0]  sensors;
  } cmta_result_t;

  // bytes of a row that fall inside the checksum span
  function automatic logic [7:0] sum_mask(input logic [CNT_W-1:0] row);
    logic [7:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      m[k] = ((8 * int'(row) + k) < SUM_BYTES);
    end
    return m;
  endfunction

  // byte position of the high byte of each sensor word
  function automatic logic [4:0] word_offset(input int k);
    logic [4:0] o;
    case (k)
      0:       o = 5'd0;
      1:       o = 5'd2;
      2:       o = 5'd4;
      3:       o = 5'd8;
      4:       o = 5'd10;
      5:       o = 5'd14;
      6:       o = 5'd16;
      7:       o = 5'd18;
      8:       o = 5'd22;
      default: o = 5'd0;
    endcase
    return o;
  endfunction

endpackage

/* rtl/cmta_front.sv */
module cmta_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [28:0]                     frame_id_i,
  input  logic                            frame_ext_i,
  input  logic [3:0]                      frame_len_i,
  input  logic [63:0]                     frame_data_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cmta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output cmta_pkg::cmta_item_t            q_item_o,
  output logic [15:0]                     timeout_o
);
  import cmta_pkg::*;

  logic [28:0] exp_id_q;
  logic        exp_ext_q;
  logic [3:0]  exp_len_q;
  logic [15:0] timeout_q;
  logic        match;
  logic [3:0]  n_bytes;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q  <= RESET_ID;
      exp_ext_q <= 1'b0;
      exp_len_q <= RESET_LEN;
      timeout_q <= RESET_TIMEOUT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_EXPECTED_ID:  exp_id_q  <= cfg_data_i[28:0];
        CFG_EXPECTED_EXT: exp_ext_q <= cfg_data_i[0];
        CFG_EXPECTED_LEN: exp_len_q <= cfg_data_i[3:0];
        CFG_TIMEOUT:      timeout_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign timeout_o  = timeout_q;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign match   = (frame_id_i == exp_id_q) && (frame_ext_i == exp_ext_q)
                   && (frame_len_i == exp_len_q);
  // lengths above eight copy a full row
  assign n_bytes = (frame_len_i > 4'd8) ? 4'd8 : frame_len_i;

  always_comb begin
    q_item_o.data   = frame_data_i;
    q_item_o.marker = (frame_data_i[7:0] == MARKER_B0) && (frame_data_i[15:8] == MARKER_B1);
    for (int k = 0; k < 8; k++) begin
      q_item_o.mask[k] = (4'(k) < n_bytes);
    end
    if (command_i) begin
      q_item_o.kind = ITEM_TICK;
    end else if (match) begin
      q_item_o.kind = ITEM_FRAME;
    end else begin
      q_item_o.kind = ITEM_SKIP;
    end
  end

endmodule

/* rtl/cmta_queue.sv */
module cmta_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cmta_pkg::cmta_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output cmta_pkg::cmta_item_t item_o
);
  import cmta_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmta_item_t         ent_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               do_push, do_pop;

  assign full_o  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign item_o  = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= item_i;
    end
  end

endmodule

/* rtl/cmta_back.sv */
module cmta_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  cmta_pkg::cmta_item_t   q_item_i,
  output logic                   q_pop_o,
  input  logic [15:0]            timeout_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output cmta_pkg::cmta_result_t result_o
);
  import cmta_pkg::*;

  localparam bit CHK_IN  = SUM_BYTES < 8 * FRAMES_PER_MESSAGE;
  localparam int CHK_POS = CHK_IN ? SUM_BYTES : 0;

  // rows hold the message buffer image: payload bytes merged over the last drain
  logic [63:0]                  store_q [FRAMES_PER_MESSAGE];
  logic [CNT_W-1:0]             count_q, count_d;
  logic [7:0]                   sum_q, sum_d;
  logic [15:0]                  elapsed_q, elapsed_d;
  logic [NUM_SENSORS-1:0][15:0] sensor_q, sensor_d;
  logic                         complete_q, connected_q, out_valid_q;

  logic              pop, is_frame, room, push, drain, pass, conn;
  logic [CNT_W-1:0]  cnt_after;
  logic [63:0]       old_row, merged;
  logic [7:0]        row_mask, row_sum, total, chk_byte;
  logic [RAW_W-1:0]  raw_now;

  assign pop      = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o  = pop;
  assign is_frame = (q_item_i.kind == ITEM_FRAME);
  assign room     = (count_q < CNT_W'(FRAMES_PER_MESSAGE));
  assign push     = pop && is_frame && room;
  assign row_mask = sum_mask(count_q);

  always_comb begin
    old_row = '0;
    for (int r = 0; r < FRAMES_PER_MESSAGE; r++) begin
      if (count_q == CNT_W'(r)) begin
        old_row = store_q[r];
      end
    end
    for (int k = 0; k < 8; k++) begin
      merged[8*k +: 8] = q_item_i.mask[k] ? q_item_i.data[8*k +: 8] : old_row[8*k +: 8];
    end
    row_sum = '0;
    for (int k = 0; k < 8; k++) begin
      if (row_mask[k]) begin
        row_sum = row_sum + merged[8*k +: 8];
      end
    end
    for (int r = 0; r < FRAMES_PER_MESSAGE; r++) begin
      raw_now[64*r +: 64] = (push && count_q == CNT_W'(r)) ? merged : store_q[r];
    end
  end

  assign cnt_after = push ? count_q + 1'b1 : count_q;
  assign drain     = pop && is_frame && q_item_i.marker
                     && (cnt_after == CNT_W'(FRAMES_PER_MESSAGE));
  assign total     = push ? sum_q + row_sum : sum_q;
  assign chk_byte  = CHK_IN ? raw_now[8*CHK_POS +: 8] : 8'h00;
  assign pass      = drain && (raw_now[8*SYNC_POS +: 8] == SYNC_B0)
                     && (raw_now[8*(SYNC_POS+1) +: 8] == SYNC_B1) && (total == chk_byte);

  always_comb begin
    elapsed_d = elapsed_q;
    if (pass) begin
      elapsed_d = '0;
    end else if (q_item_i.kind == ITEM_TICK && elapsed_q != TICK_MAX) begin
      elapsed_d = elapsed_q + 1'b1;
    end
    conn = (elapsed_d <= timeout_i);
    sensor_d = sensor_q;
    if (pass) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        sensor_d[s] = {raw_now[8*word_offset(s) +: 8], raw_now[8*word_offset(s) + 8 +: 8]};
      end
    end
    if (!conn) begin
      sensor_d = '1;
    end
    count_d = drain ? '0 : cnt_after;
    sum_d   = drain ? '0 : total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < FRAMES_PER_MESSAGE; r++) begin
        store_q[r] <= '0;
      end
      count_q     <= '0;
      sum_q       <= '0;
      elapsed_q   <= '0;
      sensor_q    <= '0;
      complete_q  <= 1'b0;
      connected_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        for (int r = 0; r < FRAMES_PER_MESSAGE; r++) begin
          store_q[r] <= raw_now[64*r +: 64];
        end
        count_q     <= count_d;
        sum_q       <= sum_d;
        elapsed_q   <= elapsed_d;
        sensor_q    <= sensor_d;
        complete_q  <= pass;
        connected_q <= conn;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_o.complete  = complete_q;
  assign result_o.connected = connected_q;
  assign result_o.sensors   = sensor_q;

endmodule

/* rtl/can_multiframe_telemetry_assembler_top.sv */
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------------------
// input     | in_valid_i / in_stall_o        | command, frame_id, frame_ext, frame_len, data
// result    | out_valid_o / out_stall_i      | message_complete, connected, nine sensors
// config    | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while out_stall_i is low; a result passes through the queue
// and then the output register before it is offered
// the back end sets the rate and retires one queued item per cycle when not stalled
// the two-entry queue takes up to two more items while a result waits on out_stall_i
// reset clears all state at once, no clearing pass; items are taken right after reset
module can_multiframe_telemetry_assembler_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [28:0]                     frame_id_i,
  input  logic                            frame_ext_i,
  input  logic [3:0]                      frame_len_i,
  input  logic [63:0]                     frame_data_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cmta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            message_complete_o,
  output logic                            connected_o,
  output logic signed [15:0]              engine_speed_o,
  output logic signed [15:0]              vehicle_speed_o,
  output logic signed [15:0]              oil_pressure_o,
  output logic signed [15:0]              engine_temp_o,
  output logic signed [15:0]              fuel_pressure_o,
  output logic signed [15:0]              throttle_o,
  output logic signed [15:0]              manifold_pressure_o,
  output logic signed [15:0]              air_temp_o,
  output logic signed [15:0]              lambda_value_o
);
  import cmta_pkg::*;

  cmta_item_t   push_item, head_item;
  cmta_result_t result;
  logic         q_full, q_push, q_valid, q_pop;
  logic [15:0]  timeout;

  cmta_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .frame_id_i   (frame_id_i),
    .frame_ext_i  (frame_ext_i),
    .frame_len_i  (frame_len_i),
    .frame_data_i (frame_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (push_item),
    .timeout_o    (timeout)
  );

  cmta_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  cmta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .timeout_i   (timeout),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign message_complete_o  = result.complete;
  assign connected_o         = result.connected;
  assign engine_speed_o      = result.sensors[0];
  assign vehicle_speed_o     = result.sensors[1];
  assign oil_pressure_o      = result.sensors[2];
  assign engine_temp_o       = result.sensors[3];
  assign fuel_pressure_o     = result.sensors[4];
  assign throttle_o          = result.sensors[5];
  assign manifold_pressure_o = result.sensors[6];
  assign air_temp_o          = result.sensors[7];
  assign lambda_value_o      = result.sensors[8];

endmodule

/* rtl/cmta_checker.sv */
module cmta_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            message_complete_o,
  input logic                            connected_o,
  input logic signed [15:0]              engine_speed_o,
  input logic signed [15:0]              vehicle_speed_o,
  input logic signed [15:0]              oil_pressure_o,
  input logic signed [15:0]              engine_temp_o,
  input logic signed [15:0]              fuel_pressure_o,
  input logic signed [15:0]              throttle_o,
  input logic signed [15:0]              manifold_pressure_o,
  input logic signed [15:0]              air_temp_o,
  input logic signed [15:0]              lambda_value_o
);

  // a fresh message clears the timer, so the link must read as up
  a_complete_connected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_complete_o |-> connected_o)
    else $error("complete message reported while disconnected");

  // lost link forces every sensor word to all ones
  a_lost_forces_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !connected_o |->
      engine_speed_o == -16'sd1 && vehicle_speed_o == -16'sd1 && oil_pressure_o == -16'sd1
      && engine_temp_o == -16'sd1 && fuel_pressure_o == -16'sd1 && throttle_o == -16'sd1
      && manifold_pressure_o == -16'sd1 && air_temp_o == -16'sd1
      && lambda_value_o == -16'sd1)
    else $error("sensor value not forced while disconnected");

  // the queue only fills up behind a result that is waiting
  a_stall_behind_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(message_complete_o)
      && $stable(connected_o) && $stable(engine_speed_o) && $stable(lambda_value_o))
    else $error("stalled result changed");

endmodule

bind can_multiframe_telemetry_assembler_top cmta_checker u_cmta_checker (.*);

/* dv/can_telemetry_monitor.sv */
package cmta_tb_pkg;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_TICK  = 1'b1
  } command_e;

  typedef struct packed {
    logic                                   complete;
    logic                                   connected;
    logic [cmta_pkg::NUM_SENSORS-1:0][15:0] sensors;
  } reading_t;

endpackage

module can_telemetry_monitor
  import cmta_pkg::*, cmta_tb_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          command_i,
  input  logic [28:0]                   frame_id_i,
  input  logic                          frame_ext_i,
  input  logic [3:0]                    frame_len_i,
  input  logic [63:0]                   frame_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          message_complete_i,
  input  logic                          connected_i,
  input  logic [NUM_SENSORS-1:0][15:0]  sensors_i,
  output int                            mismatches_o,
  output int                            awaiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMAGE_BYTES = 8 * FRAMES_PER_MESSAGE;
  localparam int WORD_POS [NUM_SENSORS] = '{0, 2, 4, 8, 10, 14, 16, 18, 22};

  string sensor_name [NUM_SENSORS] = '{"engine_speed", "vehicle_speed", "oil_pressure",
                                        "engine_temp", "fuel_pressure", "throttle",
                                        "manifold_pressure", "air_temp", "lambda_value"};

  // shadow of the registers
  logic [28:0] want_id;
  logic        want_ext;
  logic [3:0]  want_len;
  logic [15:0] want_timeout;

  // assembler state
  logic [63:0] fifo_data [FRAMES_PER_MESSAGE];
  int          fifo_len  [FRAMES_PER_MESSAGE];
  int          fifo_fill;
  logic [15:0] tick_count;
  logic [15:0] sensor_word [NUM_SENSORS];
  logic [7:0]  byte_image [IMAGE_BYTES];

  reading_t pending_readings [$];
  int       fault_count = 0;

  assign mismatches_o = fault_count;

  task automatic assemble_step(input command_e cmd, input logic [28:0] id, input logic ext,
                               input logic [3:0] len, input logic [63:0] data,
                               output reading_t r);
    logic       ok;
    logic [7:0] sum;
    ok = 1'b0;
    r  = '0;
    if (cmd == CMD_TICK) begin
      if (tick_count != TICK_MAX) tick_count++;
    end else if (id == want_id && ext == want_ext && len == want_len) begin
      if (fifo_fill < FRAMES_PER_MESSAGE) begin
        fifo_data[fifo_fill] = data;
        fifo_len[fifo_fill]  = (len > 4'd8) ? 8 : int'(len);
        fifo_fill++;
      end
      // a full queue drains on the marker even if this frame was dropped
      if (data[7:0] == MARKER_B0 && data[15:8] == MARKER_B1 &&
          fifo_fill == FRAMES_PER_MESSAGE) begin
        for (int f = 0; f < FRAMES_PER_MESSAGE; f++) begin
          for (int b = 0; b < fifo_len[f]; b++) begin
            byte_image[8 * f + b] = fifo_data[f][8 * b +: 8];
          end
        end
        fifo_fill = 0;
        if (byte_image[SYNC_POS] == SYNC_B0 && byte_image[SYNC_POS + 1] == SYNC_B1) begin
          sum = '0;
          for (int b = 0; b < SUM_BYTES; b++) sum += byte_image[b];
          ok = (sum == byte_image[SUM_BYTES]);
        end
        if (ok) begin
          tick_count = '0;
          for (int k = 0; k < NUM_SENSORS; k++) begin
            sensor_word[k] = {byte_image[WORD_POS[k]], byte_image[WORD_POS[k] + 1]};
          end
        end
      end
    end
    r.complete  = ok;
    r.connected = (tick_count <= want_timeout);
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (!r.connected) sensor_word[k] = '1;
      r.sensors[k] = sensor_word[k];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      want_id      = RESET_ID;
      want_ext     = 1'b0;
      want_len     = RESET_LEN;
      want_timeout = RESET_TIMEOUT;
      fifo_fill    = 0;
      tick_count   = '0;
      for (int k = 0; k < NUM_SENSORS; k++) sensor_word[k] = '0;
      for (int b = 0; b < IMAGE_BYTES; b++) byte_image[b] = '0;
      for (int f = 0; f < FRAMES_PER_MESSAGE; f++) begin
        fifo_data[f] = '0;
        fifo_len[f]  = 0;
      end
      pending_readings.delete();
      awaiting_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_EXPECTED_ID:  want_id      = cfg_data_i[28:0];
          CFG_EXPECTED_EXT: want_ext     = cfg_data_i[0];
          CFG_EXPECTED_LEN: want_len     = cfg_data_i[3:0];
          CFG_TIMEOUT:      want_timeout = cfg_data_i[15:0];
          default: ;
        endcase
      end

      // results first: an item taken at this edge cannot have its result out yet
      if (out_valid_i && !out_stall_i) begin
        got.complete  = message_complete_i;
        got.connected = connected_i;
        got.sensors   = sensors_i;
        if (pending_readings.size() == 0) begin
          $error("result with no reading expected");
          fault_count++;
        end else begin
          want = pending_readings.pop_front();
          if (got.complete !== want.complete) begin
            $error("message_complete: expected %0d, got %0d", want.complete, got.complete);
            fault_count++;
          end
          if (got.connected !== want.connected) begin
            $error("connected: expected %0d, got %0d", want.connected, got.connected);
            fault_count++;
          end
          for (int k = 0; k < NUM_SENSORS; k++) begin
            if (got.sensors[k] !== want.sensors[k]) begin
              $error("%s: expected %0d, got %0d", sensor_name[k],
                     $signed(want.sensors[k]), $signed(got.sensors[k]));
              fault_count++;
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        assemble_step(command_e'(command_i), frame_id_i, frame_ext_i, frame_len_i,
                      frame_data_i, want);
        pending_readings.push_back(want);
      end
      awaiting_o <= pending_readings.size();
    end
  end

endmodule

/* dv/can_multiframe_telemetry_assembler_top_tb.sv */
module can_multiframe_telemetry_assembler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmta_pkg::*;
  import cmta_tb_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          SETTLE      = 8;
  localparam int          LAST_ROW    = 8 * (FRAMES_PER_MESSAGE - 1);
  localparam logic [15:0] MARKER      = {MARKER_B1, MARKER_B0};

  typedef enum {
    MSG_GOOD,
    MSG_EARLY_MARKER,
    MSG_BAD_SYNC,
    MSG_BAD_SUM,
    MSG_NO_MARKER
  } message_e;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic                 command_i    = 1'b0;
  logic [28:0]          frame_id_i   = '0;
  logic                 frame_ext_i  = 1'b0;
  logic [3:0]           frame_len_i  = '0;
  logic [63:0]          frame_data_i = '0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [31:0]          cfg_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic                 message_complete_o;
  logic                 connected_o;
  logic signed [15:0]   engine_speed_o;
  logic signed [15:0]   vehicle_speed_o;
  logic signed [15:0]   oil_pressure_o;
  logic signed [15:0]   engine_temp_o;
  logic signed [15:0]   fuel_pressure_o;
  logic signed [15:0]   throttle_o;
  logic signed [15:0]   manifold_pressure_o;
  logic signed [15:0]   air_temp_o;
  logic signed [15:0]   lambda_value_o;

  int mismatches;
  int awaiting;

  // register values as last written
  logic [28:0] id_sel      = RESET_ID;
  logic        ext_sel     = 1'b0;
  logic [3:0]  len_sel     = RESET_LEN;

  logic [7:0]  msg_bytes [8 * FRAMES_PER_MESSAGE];
  int          fill_guess  = 0;
  int          items_sent  = 0;
  bit          tx_eager    = 1'b0;
  bit          rx_eager    = 1'b0;
  bit          hold_quiet  = 1'b0;
  int          stall_left  = 0;
  int unsigned cycle_count = 0;

  can_multiframe_telemetry_assembler_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .frame_id_i          (frame_id_i),
    .frame_ext_i         (frame_ext_i),
    .frame_len_i         (frame_len_i),
    .frame_data_i        (frame_data_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .message_complete_o  (message_complete_o),
    .connected_o         (connected_o),
    .engine_speed_o      (engine_speed_o),
    .vehicle_speed_o     (vehicle_speed_o),
    .oil_pressure_o      (oil_pressure_o),
    .engine_temp_o       (engine_temp_o),
    .fuel_pressure_o     (fuel_pressure_o),
    .throttle_o          (throttle_o),
    .manifold_pressure_o (manifold_pressure_o),
    .air_temp_o          (air_temp_o),
    .lambda_value_o      (lambda_value_o)
  );

  can_telemetry_monitor monitor (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .command_i          (command_i),
    .frame_id_i         (frame_id_i),
    .frame_ext_i        (frame_ext_i),
    .frame_len_i        (frame_len_i),
    .frame_data_i       (frame_data_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .message_complete_i (message_complete_o),
    .connected_i        (connected_o),
    .sensors_i          ({lambda_value_o, air_temp_o, manifold_pressure_o, throttle_o,
                          fuel_pressure_o, engine_temp_o, oil_pressure_o, vehicle_speed_o,
                          engine_speed_o}),
    .mismatches_o       (mismatches),
    .awaiting_o         (awaiting)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: stall for a drawn number of cycles after each result taken
  always @(posedge clk_i or negedge rst_ni) begin
    int wait_cycles;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if ($urandom_range(0, 39) == 0) rx_eager <= !rx_eager;
      wait_cycles = (hold_quiet || rx_eager) ? 0 : $urandom_range(0, 9);
      stall_left  <= wait_cycles;
      out_stall_i <= (wait_cycles != 0);
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  task automatic send_item(input command_e cmd, input logic [28:0] id, input logic ext,
                           input logic [3:0] len, input logic [63:0] data);
    int gap;
    gap = (hold_quiet || tx_eager) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    frame_id_i   <= id;
    frame_ext_i  <= ext;
    frame_len_i  <= len;
    frame_data_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (items_sent % 32 == 0) tx_eager = ($urandom_range(0, 2) == 0);
    // rough queue occupancy, only to line messages up with an empty queue
    if (cmd == CMD_FRAME && id == id_sel && ext == ext_sel && len == len_sel) begin
      if (fill_guess < FRAMES_PER_MESSAGE) fill_guess++;
      if (data[15:0] == MARKER && fill_guess == FRAMES_PER_MESSAGE) fill_guess = 0;
    end
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 29'($urandom), 1'($urandom), 4'($urandom), {$urandom, $urandom});
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaiting != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
                           input int width);
    logic [31:0] mask;
    logic [31:0] word;
    mask = (32'h1 << width) - 32'h1;
    word = $urandom;
    // junk above the register width must be dropped
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= (word & ~mask) | (value & mask);
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_config(input logic [28:0] id, input logic ext, input logic [3:0] len,
                            input logic [15:0] timeout);
    pause_until_drained();
    write_reg(CFG_EXPECTED_ID, 32'(id), 29);
    write_reg(CFG_EXPECTED_EXT, 32'(ext), 1);
    write_reg(CFG_EXPECTED_LEN, 32'(len), 4);
    write_reg(CFG_TIMEOUT, 32'(timeout), 16);
    cfg_valid_i <= 1'b0;
    id_sel  = id;
    ext_sel = ext;
    len_sel = len;
  endtask

  task automatic build_message(input message_e kind, input bit extremes);
    logic [7:0] sum;
    foreach (msg_bytes[b]) msg_bytes[b] = 8'($urandom);
    if (extremes) begin
      msg_bytes[0] = 8'h7F;
      msg_bytes[1] = 8'hFF;
      msg_bytes[2] = 8'h80;
      msg_bytes[3] = 8'h00;
      msg_bytes[4] = 8'hFF;
      msg_bytes[5] = 8'hFF;
      msg_bytes[8] = 8'h00;
      msg_bytes[9] = 8'h00;
    end
    msg_bytes[SYNC_POS]     = SYNC_B0;
    msg_bytes[SYNC_POS + 1] = SYNC_B1;
    msg_bytes[LAST_ROW]     = MARKER_B0;
    msg_bytes[LAST_ROW + 1] = MARKER_B1;
    if (kind == MSG_EARLY_MARKER) begin
      msg_bytes[0] = MARKER_B0;
      msg_bytes[1] = MARKER_B1;
    end
    if (kind == MSG_NO_MARKER)
      msg_bytes[LAST_ROW + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    sum = '0;
    for (int b = 0; b < SUM_BYTES; b++) sum += msg_bytes[b];
    msg_bytes[SUM_BYTES] = sum;
    if (kind == MSG_BAD_SYNC)
      msg_bytes[SYNC_POS + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    if (kind == MSG_BAD_SUM)
      msg_bytes[SUM_BYTES] ^= 8'($urandom_range(1, 255));
  endtask

  // frame that the block should drop, or a tick
  task automatic send_stray();
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] data;
    id   = id_sel;
    ext  = ext_sel;
    len  = len_sel;
    data = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) data[15:0] = MARKER;
    case ($urandom_range(0, 3))
      0: id  = id ^ 29'($urandom_range(1, 32'h1FFF_FFFF));
      1: ext = !ext;
      2: len = len ^ 4'($urandom_range(1, 15));
      default: ;
    endcase
    if (id == id_sel && ext == ext_sel && len == len_sel) send_tick();
    else send_item(CMD_FRAME, id, ext, len, data);
  endtask

  // anything at all, matching or not
  task automatic send_noise_frame();
    logic [63:0] data;
    data = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) data[15:0] = MARKER;
    send_item(CMD_FRAME,
              $urandom_range(0, 1) ? id_sel : 29'($urandom),
              $urandom_range(0, 3) != 0 ? ext_sel : 1'($urandom),
              $urandom_range(0, 1) ? len_sel : 4'($urandom),
              data);
  endtask

  task automatic send_message(input message_e kind, input bit extremes);
    logic [63:0] word;
    // fill up and flush whatever is left in the queue
    while (fill_guess != 0) begin
      word = {$urandom, $urandom};
      if (fill_guess == FRAMES_PER_MESSAGE - 1 && word[15:0] == MARKER) word[0] = !word[0];
      if (fill_guess == FRAMES_PER_MESSAGE) word[15:0] = MARKER;
      send_item(CMD_FRAME, id_sel, ext_sel, len_sel, word);
    end
    build_message(kind, extremes);
    for (int f = 0; f < FRAMES_PER_MESSAGE; f++) begin
      if ($urandom_range(0, 7) == 0) send_stray();
      for (int b = 0; b < 8; b++) word[8 * b +: 8] = msg_bytes[8 * f + b];
      send_item(CMD_FRAME, id_sel, ext_sel, len_sel, word);
    end
  endtask

  task automatic run_traffic(input int quota);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) send_message(MSG_GOOD, 1'b0);
      else if (pick < 60) send_message(MSG_EARLY_MARKER, 1'b0);
      else if (pick < 65) send_message(MSG_BAD_SYNC, 1'b0);
      else if (pick < 70) send_message(MSG_BAD_SUM, 1'b0);
      else if (pick < 74) send_message(MSG_NO_MARKER, 1'b0);
      else if (pick < 86) begin
        repeat ($urandom_range(0, 7) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 4))
          send_tick();
      end else if (pick < 92) send_stray();
      else if (pick < 98) send_noise_frame();
      else pause_until_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ignored fields, mismatching frames, then four message kinds
    send_item(CMD_TICK, '1, 1'b1, 4'hF, '1);
    send_item(CMD_FRAME, RESET_ID, 1'b1, RESET_LEN, {48'h0, MARKER});
    send_item(CMD_FRAME, RESET_ID ^ 29'h1, 1'b0, RESET_LEN, {48'h0, MARKER});
    send_item(CMD_FRAME, RESET_ID, 1'b0, RESET_LEN - 4'd1, {48'h0, MARKER});
    send_message(MSG_GOOD, 1'b1);
    send_message(MSG_BAD_SYNC, 1'b0);
    send_message(MSG_BAD_SUM, 1'b0);
    send_message(MSG_NO_MARKER, 1'b0);
    // queue is full: this one is dropped but still sets off the check
    send_item(CMD_FRAME, id_sel, ext_sel, len_sel, {16'h0, 32'($urandom), MARKER});

    run_traffic(250);
    set_config(29'h1FFF_FFFF, 1'b1, 4'd8, 16'd0);
    run_traffic(250);
    set_config(29'h0, 1'b0, 4'd0, 16'd3);
    run_traffic(250);
    set_config(29'($urandom), 1'b1, 4'd15, 16'd20);
    run_traffic(250);
    set_config(29'h0AAA_AAAA, 1'b0, 4'd3, 16'hFFFE);
    run_traffic(250);
    set_config(RESET_ID, 1'b0, RESET_LEN, 16'd10);
    run_traffic(275);

    // widest timeout: the link must stay up however many ticks come
    set_config(RESET_ID, 1'b0, RESET_LEN, 16'hFFFF);
    hold_quiet = 1'b1;
    repeat (40) send_tick();
    set_config(RESET_ID, 1'b0, RESET_LEN, 16'hFFFE);
    repeat (3) send_tick();
    hold_quiet = 1'b0;
    send_message(MSG_GOOD, 1'b0);

    pause_until_drained();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cmta_pkg.sv
rtl/cmta_front.sv
rtl/cmta_queue.sv
rtl/cmta_back.sv
rtl/can_multiframe_telemetry_assembler_top.sv
rtl/cmta_checker.sv
dv/can_telemetry_monitor.sv
dv/can_multiframe_telemetry_assembler_top_tb.sv
